// ===== rtl/knn_pkg.sv =====
// Shared types and constants of the k-nearest-neighbor vote unit.
package knn_pkg;

	localparam int DEF_NEIGHBORS = 10;
	localparam int DEF_CLASSES   = 4;

	localparam int COORD_W    = 16;
	localparam int ABS_W      = 16;
	localparam int SQ_W       = 2 * ABS_W;
	localparam int DIST_W     = 33;
	localparam int LABEL_W    = 2;
	localparam int VOTES_W    = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = CFG_IDX_W'(1);

	typedef struct packed {
		logic load;
		logic square;
		logic insert;
		logic vote_clear;
		logic vote_step;
		logic out_load;
		logic list_clear;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic vote_last;
	} sts_t;

endpackage

// ===== rtl/knn_ctrl.sv =====
// Controller state machine of the k-nearest-neighbor vote unit.
module knn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  knn_pkg::sts_t  sts,
	output knn_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_INSERT,
		ST_VOTE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load = s_tvalid;
			ST_SQUARE: cmd.square = 1'b1;
			ST_INSERT: begin
				cmd.insert     = 1'b1;
				cmd.vote_clear = sts.last;
			end
			ST_VOTE:   cmd.vote_step = 1'b1;
			ST_FINISH: begin
				cmd.out_load   = out_free;
				cmd.list_clear = out_free;
			end
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_SQUARE;
				end
				ST_SQUARE: state_q <= ST_INSERT;
				ST_INSERT: state_q <= sts.last ? ST_VOTE : ST_IDLE;
				ST_VOTE: begin
					if (sts.vote_last)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/knn_dp.sv =====
// Datapath: query registers, distance, sorted neighbor list, vote counters, result.
module knn_dp #(
	parameter int NEIGHBORS = knn_pkg::DEF_NEIGHBORS,
	parameter int CLASSES   = knn_pkg::DEF_CLASSES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [knn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [knn_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic signed [knn_pkg::COORD_W-1:0] point_x,
	input  logic signed [knn_pkg::COORD_W-1:0] point_y,
	input  logic [knn_pkg::LABEL_W-1:0]       point_label,
	input  logic                              last_point,
	input  knn_pkg::cmd_t                     cmd,
	output knn_pkg::sts_t                     sts,
	output logic [knn_pkg::LABEL_W-1:0]       class_label,
	output logic [knn_pkg::VOTES_W-1:0]       winning_votes
);

	localparam int IDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
	localparam int CNT_W = $clog2(NEIGHBORS + 1);
	localparam int CLS_W = $clog2(CLASSES);
	localparam int DIST_W = knn_pkg::DIST_W;
	localparam int LABEL_W = knn_pkg::LABEL_W;
	localparam int ABS_W = knn_pkg::ABS_W;
	localparam int SQ_W = knn_pkg::SQ_W;

	logic signed [knn_pkg::COORD_W-1:0] query_x_q;
	logic signed [knn_pkg::COORD_W-1:0] query_y_q;

	logic [ABS_W-1:0]   dx_abs_s1;
	logic [ABS_W-1:0]   dy_abs_s1;
	logic [LABEL_W-1:0] label_s1;
	logic               last_s1;
	logic [SQ_W-1:0]    sqx_s2;
	logic [SQ_W-1:0]    sqy_s2;
	logic [LABEL_W-1:0] label_s2;
	logic               last_s2;

	logic [DIST_W-1:0]  dist_q  [NEIGHBORS];
	logic [LABEL_W-1:0] label_q [NEIGHBORS];
	logic [NEIGHBORS-1:0] valid_q;

	logic [CNT_W-1:0]   votes_q [CLASSES];
	logic [IDX_W-1:0]   vote_idx_q;
	logic [CNT_W-1:0]   best_cnt_q;
	logic [LABEL_W-1:0] best_label_q;

	logic [knn_pkg::COORD_W:0] dx;
	logic [knn_pkg::COORD_W:0] dy;
	logic [DIST_W-1:0]   dist_new;
	logic [NEIGHBORS-1:0] take;

	logic [LABEL_W-1:0] rd_label;
	logic               rd_votes;
	logic [CLS_W-1:0]   cls_idx;
	logic [CNT_W-1:0]   cnt_next;

	assign dx = {query_x_q[knn_pkg::COORD_W-1], query_x_q} - {point_x[knn_pkg::COORD_W-1], point_x};
	assign dy = {query_y_q[knn_pkg::COORD_W-1], query_y_q} - {point_y[knn_pkg::COORD_W-1], point_y};

	assign dist_new = DIST_W'(sqx_s2) + DIST_W'(sqy_s2);

	always_comb begin
		for (int j = 0; j < NEIGHBORS; j++)
			take[j] = !valid_q[j] || (dist_new < dist_q[j]);
	end

	assign rd_label = label_q[vote_idx_q];
	assign rd_votes = valid_q[vote_idx_q] && (32'(rd_label) < CLASSES);
	assign cls_idx  = CLS_W'(rd_label);
	assign cnt_next = votes_q[cls_idx] + CNT_W'(1);

	assign sts.last      = last_s2;
	assign sts.vote_last = (vote_idx_q == IDX_W'(NEIGHBORS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				knn_pkg::REG_QUERY_X: query_x_q <= cfg_data;
				knn_pkg::REG_QUERY_Y: query_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_abs_s1 <= dx[knn_pkg::COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
			dy_abs_s1 <= dy[knn_pkg::COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
			label_s1  <= point_label;
			last_s1   <= last_point;
		end
		if (cmd.square) begin
			sqx_s2   <= dx_abs_s1 * dx_abs_s1;
			sqy_s2   <= dy_abs_s1 * dy_abs_s1;
			label_s2 <= label_s1;
			last_s2  <= last_s1;
		end
	end

	// sorted insert: take[] is monotone, the first set bit is the insert slot
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int j = 0; j < NEIGHBORS; j++) begin
				if (take[j]) begin
					if (j == 0 || !take[(j > 0) ? j - 1 : 0]) begin
						dist_q[j]  <= dist_new;
						label_q[j] <= label_s2;
					end else begin
						dist_q[j]  <= dist_q[(j > 0) ? j - 1 : 0];
						label_q[j] <= label_q[(j > 0) ? j - 1 : 0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.list_clear) begin
			valid_q <= '0;
		end else if (cmd.insert) begin
			for (int j = 0; j < NEIGHBORS; j++)
				if (take[j])
					valid_q[j] <= (j == 0) ? 1'b1 : (valid_q[(j > 0) ? j - 1 : 0] ||
						!take[(j > 0) ? j - 1 : 0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.vote_clear) begin
			for (int c = 0; c < CLASSES; c++)
				votes_q[c] <= '0;
			vote_idx_q   <= '0;
			best_cnt_q   <= '0;
			best_label_q <= '0;
		end else if (cmd.vote_step) begin
			if (rd_votes) begin
				votes_q[cls_idx] <= cnt_next;
				if (cnt_next > best_cnt_q) begin
					best_cnt_q   <= cnt_next;
					best_label_q <= rd_label;
				end
			end
			if (!sts.vote_last)
				vote_idx_q <= vote_idx_q + IDX_W'(1);
		end
		if (cmd.out_load) begin
			class_label   <= best_label_q;
			winning_votes <= (32'(best_cnt_q) > 15) ? knn_pkg::VOTES_W'(15) :
				knn_pkg::VOTES_W'(best_cnt_q);
		end
	end

endmodule

// ===== rtl/knn_sorted_insert_vote_unit.sv =====
// Top level of the k-nearest-neighbor classifier with sorted insert and vote.
//
// Each dataset point passes a register stage for the coordinate
// differences, one for the two squares, and one for the distance add and the
// parallel compare-and-shift insert into the sorted list; for a point without
// tlast, s_tready is high again after the insert. A point marked with tlast
// then goes through voting, one kept neighbor per cycle through the shared
// counter update, and then waits until the previous result has been taken to
// load the result register and clear the list. A result waits in its output
// register while new points stream in. The user must write query coordinates
// through the cfg channel only while the unit idles; the unit does not enforce it.
module knn_sorted_insert_vote_unit #(
	parameter int NEIGHBORS = knn_pkg::DEF_NEIGHBORS,
	parameter int CLASSES   = knn_pkg::DEF_CLASSES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [knn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [knn_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// point_x [15:0], point_y [31:16], point_label [33:32], zero [39:34]
	input  logic [knn_pkg::S_TDATA_W-1:0]   s_tdata,
	// last_point
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// class_label [1:0], winning_votes [5:2], zero [7:6]
	output logic [knn_pkg::M_TDATA_W-1:0]   m_tdata
);

	knn_pkg::cmd_t cmd;
	knn_pkg::sts_t sts;
	logic [knn_pkg::LABEL_W-1:0] class_label;
	logic [knn_pkg::VOTES_W-1:0] winning_votes;

	assign cfg_ready = 1'b1;
	assign m_tdata = {{(knn_pkg::M_TDATA_W - knn_pkg::LABEL_W - knn_pkg::VOTES_W){1'b0}},
		winning_votes, class_label};

	knn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	knn_dp #(
		.NEIGHBORS (NEIGHBORS),
		.CLASSES   (CLASSES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.point_x       (s_tdata[15:0]),
		.point_y       (s_tdata[31:16]),
		.point_label   (s_tdata[33:32]),
		.last_point    (s_tlast),
		.cmd           (cmd),
		.sts           (sts),
		.class_label   (class_label),
		.winning_votes (winning_votes)
	);

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the k-nearest-neighbor sorted insert and vote unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import knn_pkg::*;

	localparam int                   KEEP       = DEF_NEIGHBORS;
	localparam int                   NCLASS     = DEF_CLASSES;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);
	localparam int                   IDLE_PCT   = 16;
	localparam int                   HOLD_CYC   = 400;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [LABEL_W-1:0]        label;
		logic                      last;
	} point_t;

	typedef struct {
		logic [LABEL_W-1:0] class_label;
		logic [VOTES_W-1:0] winning_votes;
	} vote_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;

	knn_sorted_insert_vote_unit uut (.*);

	// predictor state
	logic signed [COORD_W-1:0] q_x = '0;
	logic signed [COORD_W-1:0] q_y = '0;
	logic [DIST_W-1:0]         kept_dist [KEEP];
	logic [LABEL_W-1:0]        kept_label [KEEP];
	logic                      kept_valid [KEEP];

	point_t point_q [$];
	vote_t  vote_q [$];
	point_t cur_point;
	bit     in_taken;
	bit     calm;
	int     hold_req_cnt;
	int     hold_seen;
	int     hold_left;
	int     n_points;
	int     n_votes;
	int     n_writes;
	int     n_settings;
	int     fails;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("tb failed");
		$finish;
	end

	task automatic clear_kept();
		for (int j = 0; j < KEEP; j++) begin
			kept_dist[j]  = '1;
			kept_label[j] = '0;
			kept_valid[j] = 1'b0;
		end
	endtask

	// insert one point into the sorted list; on the last point, tally and queue the vote
	task automatic rank_and_vote(input point_t p);
		longint            dx;
		longint            dy;
		logic [DIST_W-1:0] d;
		int                pos;
		int                tally [NCLASS];
		int                best_n;
		int                best_l;
		vote_t             v;
		dx = longint'(q_x) - longint'(p.x);
		dy = longint'(q_y) - longint'(p.y);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		d = DIST_W'(dx * dx + dy * dy);
		pos = KEEP;
		for (int j = 0; j < KEEP; j++) begin
			if (!kept_valid[j] || d < kept_dist[j]) begin
				pos = j;
				break;
			end
		end
		if (pos < KEEP) begin
			for (int j = KEEP - 1; j > pos; j--) begin
				kept_dist[j]  = kept_dist[j-1];
				kept_label[j] = kept_label[j-1];
				kept_valid[j] = kept_valid[j-1];
			end
			kept_dist[pos]  = d;
			kept_label[pos] = p.label;
			kept_valid[pos] = 1'b1;
		end
		if (p.last) begin
			for (int c = 0; c < NCLASS; c++)
				tally[c] = 0;
			best_n = 0;
			best_l = 0;
			for (int j = 0; j < KEEP; j++) begin
				if (kept_valid[j] && int'(kept_label[j]) < NCLASS) begin
					tally[kept_label[j]]++;
					if (tally[kept_label[j]] > best_n) begin
						best_n = tally[kept_label[j]];
						best_l = kept_label[j];
					end
				end
			end
			v.class_label   = LABEL_W'(best_l);
			v.winning_votes = VOTES_W'(best_n > 15 ? 15 : best_n);
			vote_q.push_back(v);
			clear_kept();
		end
	endtask

	// input side: acceptance, prediction and result check at the rising edge
	always @(posedge clk) begin
		vote_t e;
		in_taken = s_tvalid && s_tready;
		if (in_taken) begin
			rank_and_vote(cur_point);
			n_points++;
		end
		if (m_tvalid && m_tready) begin
			if (vote_q.size() == 0) begin
				$error("result with no vote pending: tdata %h", m_tdata);
				fails++;
			end else begin
				e = vote_q.pop_front();
				n_votes++;
				if (m_tdata[1:0] !== e.class_label) begin
					$error("class_label expected %0d got %0d", e.class_label, m_tdata[1:0]);
					fails++;
				end
				if (m_tdata[5:2] !== e.winning_votes) begin
					$error("winning_votes expected %0d got %0d",
						e.winning_votes, m_tdata[5:2]);
					fails++;
				end
			end
		end
	end

	// point driver
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (point_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				cur_point = point_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {{(S_TDATA_W - 2 * COORD_W - LABEL_W){1'b0}},
					cur_point.label, cur_point.y, cur_point.x};
				s_tlast  <= cur_point.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_seen != hold_req_cnt) begin
			hold_seen = hold_req_cnt;
			hold_left = HOLD_CYC;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic point_t mk_point(input int x, input int y, input int label,
		input bit last);
		point_t p;
		p.x     = COORD_W'(x);
		p.y     = COORD_W'(y);
		p.label = LABEL_W'(label);
		p.last  = last;
		return p;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_QUERY_X)
			q_x = CFG_DATA_W'(value);
		else if (idx == REG_QUERY_Y)
			q_y = CFG_DATA_W'(value);
		n_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_query(input int x, input int y);
		write_reg(REG_QUERY_X, x);
		write_reg(REG_QUERY_Y, y);
		n_settings++;
	endtask

	task automatic drain();
		while (point_q.size() != 0 || s_tvalid || vote_q.size() != 0)
			@(posedge clk);
		repeat (KEEP + 8) @(posedge clk);
	endtask

	// one random query run ending in a tagged point
	task automatic push_run(input int len);
		point_t p;
		point_t prev;
		int     r;
		prev = mk_point(q_x, q_y, 0, 1'b0);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				p = mk_point($urandom, $urandom, 0, 1'b0);
			else if (r < 30)
				p = prev;
			else if (r < 38)
				p = mk_point(q_x, q_y, 0, 1'b0);
			else
				p = mk_point(int'(q_x) + $urandom_range(0, 3000) - 1500,
					int'(q_y) + $urandom_range(0, 3000) - 1500, 0, 1'b0);
			p.label = LABEL_W'($urandom_range(0, 3));
			p.last  = (i == len - 1);
			point_q.push_back(p);
			prev = p;
		end
	endtask

	initial begin
		int left;
		int len;
		clear_kept();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: query at the origin
		set_query(0, 0);
		point_q.push_back(mk_point(0, 0, 1, 1'b1));
		for (int i = 0; i < 12; i++)
			point_q.push_back(mk_point(256, 0, i % 4, i == 11));
		point_q.push_back(mk_point(-32768, -32768, 3, 1'b0));
		point_q.push_back(mk_point(32767, 32767, 2, 1'b0));
		point_q.push_back(mk_point(-32768, 32767, 1, 1'b0));
		point_q.push_back(mk_point(32767, -32768, 1, 1'b1));
		drain();
		// farthest possible points, two-way label tie settled by list order
		set_query(32767, 32767);
		point_q.push_back(mk_point(-32768, -32768, 2, 1'b0));
		point_q.push_back(mk_point(-32768, -32768, 1, 1'b0));
		point_q.push_back(mk_point(32767, 32767, 1, 1'b0));
		point_q.push_back(mk_point(32767, 32767, 2, 1'b1));
		drain();
		write_reg(REG_UNUSED, 16'h1234);
		set_query(-32768, -32768);
		point_q.push_back(mk_point(32767, 32767, 3, 1'b0));
		point_q.push_back(mk_point(-32768, -32767, 0, 1'b1));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_query(32767, -32768);
				1: set_query(-25600, 25600);
				2: set_query(25600, -25600);
				default: set_query($urandom_range(0, 51200) - 25600,
					$urandom_range(0, 51200) - 25600);
			endcase
			calm = (ph == 3);
			if (ph == 5)
				hold_req_cnt++;
			left = 200;
			while (left > 0) begin
				if (ph == 5)
					len = $urandom_range(1, 3);
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(11, 40);
				else
					len = $urandom_range(1, 14);
				push_run(len);
				left -= len;
			end
			drain();
		end
		calm = 1'b0;

		$display("sent %0d points under %0d query settings (%0d register writes)",
			n_points, n_settings, n_writes);
		$display("checked %0d votes, %0d mismatches", n_votes, fails);
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
